@@ hw/rtl/scpa_pkg.sv @@
// Shared types, codes and helpers for the size class page allocator.
package scpa_pkg;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;
  localparam logic [1:0] FUNC_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_PAGES  = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_UNASSIGN  = 2'd3;

  localparam logic [15:0] MAX_CLASS_BYTES = 16'd2048;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLAIM,
    OP_POP,
    OP_DEC,
    OP_PUSH
  } sc_op_e;

  // Command broadcast to the page cells.
  typedef struct packed {
    sc_op_e     op;
    logic [2:0] cls;
    logic [8:0] val;
  } sc_cmd_t;

  // Page state seen by the controller (zero unless the cell is selected).
  typedef struct packed {
    logic [3:0] cls;
    logic [8:0] head;
    logic [8:0] top;
  } sc_view_t;

  // First slot past the header for class c.
  function automatic logic [8:0] first_slot(logic [2:0] c, int unsigned hdr);
    logic [12:0] t;
    t = 13'(hdr) + (13'd16 << c) - 13'd1;
    return 9'(t >> ({1'b0, c} + 4'd4));
  endfunction

  // Smallest class whose size holds req (req <= 2048).
  function automatic logic [2:0] class_of(logic [15:0] req);
    logic [2:0] c;
    c = 3'd0;
    for (int k = 0; k < 7; k++) begin
      if (req > (16'd16 << k)) c = 3'(k + 1);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/size_class_page_allocator.sv @@
// Size class page allocator top level: page cell chain plus slot link memory.
// Allocate: a search token walks the page chain one page per cycle; a hit on a page
//   with a freed slot adds a link memory read before the result.
// Free and size query go via a page check state; oversize or unknown answers from idle.
// One transaction at a time; busy is high until the result strobe.
// Reset clears all page classes and the claim count; the link memory needs no clearing.
module size_class_page_allocator #(
  parameter int POOL_PAGES   = 64,
  parameter int HEADER_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [15:0] request_size_i,
  input  logic [17:0] object_address_i,
  output logic        done_o,
  output logic [17:0] granted_address_o,
  output logic [11:0] object_bytes_o,
  output logic [1:0]  status_o
);

  localparam int PW = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int CW = $clog2(POOL_PAGES + 1);
  localparam int AW = PW + 8;
  localparam int MEM_D = POOL_PAGES * 256;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LINK = 2'd2;
  localparam logic [1:0] S_CHK  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [1:0]    func_q, func_d;
  logic [2:0]    cls_q, cls_d;
  logic [17:0]   addr_q, addr_d;
  logic [PW-1:0] page_q, page_d;
  logic [8:0]    slot_q, slot_d;
  logic [CW-1:0] claimed_q, claimed_d;
  logic          done_q, done_d;
  logic [17:0]   gaddr_q, gaddr_d;
  logic [11:0]   bytes_q, bytes_d;
  logic [1:0]    stat_q, stat_d;

  scpa_pkg::sc_cmd_t cmd;
  logic [PW-1:0]     cmd_page;
  logic              rd_en;
  logic [PW-1:0]     rd_page;
  logic              inject;

  logic [POOL_PAGES:0]  tok;
  logic [POOL_PAGES-1:0] hit, miss;
  scpa_pkg::sc_view_t    view [POOL_PAGES];
  scpa_pkg::sc_view_t    v;
  logic [PW-1:0]         hit_page;
  logic                  hit_any, miss_any;

  logic [8:0]    link_mem [MEM_D];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [8:0]    mem_wd, mem_rd_q;

  function automatic logic [17:0] mk_addr(logic [PW-1:0] p, logic [8:0] s, logic [2:0] c);
    logic [31:0] a;
    a = (32'(p) << 12) + (32'(s) << ({1'b0, c} + 4'd4));
    return a[17:0];
  endfunction

  assign tok[0] = inject;

  for (genvar i = 0; i < POOL_PAGES; i++) begin : g_cell
    scpa_cell #(.IDX(i), .PW(PW), .HDR(HEADER_BYTES)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_i      (tok[i]),
      .srch_cls_i (cls_q),
      .cmd_i      (cmd),
      .cmd_page_i (cmd_page),
      .rd_en_i    (rd_en),
      .rd_page_i  (rd_page),
      .tok_o      (tok[i+1]),
      .hit_o      (hit[i]),
      .miss_o     (miss[i]),
      .view_o     (view[i])
    );
  end

  always_comb begin
    v        = '0;
    hit_page = '0;
    for (int i = 0; i < POOL_PAGES; i++) begin
      v = v | view[i];
      if (hit[i]) hit_page = hit_page | PW'(i);
    end
    hit_any  = |hit;
    miss_any = (|miss) | tok[POOL_PAGES];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) link_mem[mem_wa] <= mem_wd;
    if (mem_re) mem_rd_q <= link_mem[mem_ra];
  end

  always_comb begin
    logic [5:0]  pg;
    logic        in_range;
    logic [2:0]  c;
    logic [8:0]  slot;
    logic [8:0]  top0;

    state_d   = state_q;
    func_d    = func_q;
    cls_d     = cls_q;
    addr_d    = addr_q;
    page_d    = page_q;
    slot_d    = slot_q;
    claimed_d = claimed_q;
    done_d    = 1'b0;
    gaddr_d   = gaddr_q;
    bytes_d   = bytes_q;
    stat_d    = stat_q;
    cmd       = '{op: scpa_pkg::OP_NONE, cls: cls_q, val: 9'd0};
    cmd_page  = '0;
    rd_en     = 1'b0;
    rd_page   = page_q;
    inject    = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wa    = '0;
    mem_ra    = '0;
    mem_wd    = '0;

    pg       = addr_q[17:12];
    in_range = (32'(pg) < 32'(POOL_PAGES));
    c        = v.cls[2:0] - 3'd1;
    slot     = 9'(addr_q[11:0] >> ({1'b0, c} + 4'd4));
    top0     = 9'(32'd4096 >> ({1'b0, cls_q} + 4'd4));

    case (state_q)
      S_IDLE: begin
        if (start) begin
          func_d = func_i;
          addr_d = object_address_i;
          case (func_i)
            scpa_pkg::FUNC_ALLOC: begin
              if (request_size_i > scpa_pkg::MAX_CLASS_BYTES) begin
                done_d  = 1'b1;
                gaddr_d = '0;
                bytes_d = '0;
                stat_d  = scpa_pkg::ST_TOO_LARGE;
              end else begin
                cls_d   = scpa_pkg::class_of(request_size_i);
                inject  = 1'b1;
                state_d = S_SCAN;
              end
            end
            scpa_pkg::FUNC_FREE, scpa_pkg::FUNC_QUERY: begin
              page_d  = PW'(32'(object_address_i[17:12]));
              state_d = S_CHK;
            end
            default: begin
              done_d  = 1'b1;
              gaddr_d = '0;
              bytes_d = '0;
              stat_d  = scpa_pkg::ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit_any) begin
          page_d = hit_page;
          if (v.head != 9'd0) begin
            mem_re  = 1'b1;
            mem_ra  = {hit_page, v.head[7:0]};
            slot_d  = v.head;
            state_d = S_LINK;
          end else begin
            cmd.op   = scpa_pkg::OP_DEC;
            cmd_page = hit_page;
            done_d   = 1'b1;
            gaddr_d  = mk_addr(hit_page, v.top - 9'd1, cls_q);
            bytes_d  = 12'(32'd16 << cls_q);
            stat_d   = scpa_pkg::ST_OK;
            state_d  = S_IDLE;
          end
        end else if (miss_any) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
          if (32'(claimed_q) >= 32'(POOL_PAGES)) begin
            gaddr_d = '0;
            bytes_d = '0;
            stat_d  = scpa_pkg::ST_NO_PAGES;
          end else begin
            cmd.op    = scpa_pkg::OP_CLAIM;
            cmd.val   = top0 - 9'd1;
            cmd_page  = PW'(claimed_q);
            claimed_d = claimed_q + CW'(1);
            gaddr_d   = mk_addr(PW'(claimed_q), top0 - 9'd1, cls_q);
            bytes_d   = 12'(32'd16 << cls_q);
            stat_d    = scpa_pkg::ST_OK;
          end
        end
      end
      S_LINK: begin
        cmd.op   = scpa_pkg::OP_POP;
        cmd.val  = mem_rd_q;
        cmd_page = page_q;
        done_d   = 1'b1;
        gaddr_d  = mk_addr(page_q, slot_q, cls_q);
        bytes_d  = 12'(32'd16 << cls_q);
        stat_d   = scpa_pkg::ST_OK;
        state_d  = S_IDLE;
      end
      S_CHK: begin
        rd_en   = in_range;
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (!in_range || v.cls == 4'd0) begin
          gaddr_d = '0;
          bytes_d = '0;
          stat_d  = scpa_pkg::ST_UNASSIGN;
        end else begin
          gaddr_d = '0;
          bytes_d = 12'(32'd16 << c);
          stat_d  = scpa_pkg::ST_OK;
          // slots inside the header are ignored
          if (func_q == scpa_pkg::FUNC_FREE &&
              slot >= scpa_pkg::first_slot(c, HEADER_BYTES)) begin
            mem_we   = 1'b1;
            mem_wa   = {page_q, slot[7:0]};
            mem_wd   = v.head;
            cmd.op   = scpa_pkg::OP_PUSH;
            cmd.val  = slot;
            cmd_page = page_q;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      claimed_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      claimed_q <= claimed_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    cls_q   <= cls_d;
    addr_q  <= addr_d;
    page_q  <= page_d;
    slot_q  <= slot_d;
    gaddr_q <= gaddr_d;
    bytes_q <= bytes_d;
    stat_q  <= stat_d;
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign granted_address_o = gaddr_q;
  assign object_bytes_o    = bytes_q;
  assign status_o          = stat_q;

endmodule

@@ hw/rtl/scpa_cell.sv @@
// One page cell: holds a page's class, freed list head and uncarved top slot.
module scpa_cell #(
  parameter int IDX = 0,
  parameter int PW  = 6,
  parameter int HDR = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_i,
  input  logic [2:0]        srch_cls_i,
  input  scpa_pkg::sc_cmd_t cmd_i,
  input  logic [PW-1:0]     cmd_page_i,
  input  logic              rd_en_i,
  input  logic [PW-1:0]     rd_page_i,
  output logic              tok_o,
  output logic              hit_o,
  output logic              miss_o,
  output scpa_pkg::sc_view_t view_o
);

  logic       tok_q;
  logic [3:0] cls_q;
  logic [8:0] head_q;
  logic [8:0] top_q;
  logic       match;
  logic       own_cmd;
  logic       sel;

  assign own_cmd = (cmd_page_i == PW'(IDX));

  assign match = (cls_q != 4'd0) && (cls_q == {1'b0, srch_cls_i} + 4'd1) &&
                 ((head_q != 9'd0) || (top_q > scpa_pkg::first_slot(srch_cls_i, HDR)));

  assign hit_o  = tok_q & match;
  assign miss_o = tok_q & (cls_q == 4'd0);
  assign tok_o  = tok_q & ~match & (cls_q != 4'd0);

  assign sel    = hit_o | (rd_en_i & (rd_page_i == PW'(IDX)));
  assign view_o = sel ? scpa_pkg::sc_view_t'{cls: cls_q, head: head_q, top: top_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
      cls_q <= 4'd0;
    end else begin
      tok_q <= tok_i;
      if (own_cmd && cmd_i.op == scpa_pkg::OP_CLAIM) cls_q <= {1'b0, cmd_i.cls} + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (own_cmd) begin
      case (cmd_i.op)
        scpa_pkg::OP_CLAIM: begin
          head_q <= 9'd0;
          top_q  <= cmd_i.val;
        end
        scpa_pkg::OP_POP:  head_q <= cmd_i.val;
        scpa_pkg::OP_PUSH: head_q <= cmd_i.val;
        scpa_pkg::OP_DEC:  top_q  <= top_q - 9'd1;
        default: ;
      endcase
    end
  end

endmodule

@@ tb/scpa_checker.sv @@
`timescale 1ns / 100ps
// Checker: mirrors the allocator's page state and compares every result transaction.
module scpa_checker #(
  parameter int POOL_PAGES   = 64,
  parameter int HEADER_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  func_i,
  input  logic [15:0] request_size_i,
  input  logic [17:0] object_address_i,
  input  logic        done_o,
  input  logic [17:0] granted_address_o,
  input  logic [11:0] object_bytes_o,
  input  logic [1:0]  status_o,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [17:0] addr;
    logic [11:0] bytes;
    logic [1:0]  status;
  } grant_t;

  logic [3:0] pg_class [POOL_PAGES];
  logic [8:0] pg_head  [POOL_PAGES];
  logic [8:0] pg_top   [POOL_PAGES];
  logic [8:0] link_mem [POOL_PAGES*256];
  int         claimed;
  grant_t     grant_q [$];

  function automatic int hdr_slots(int sz);
    return (HEADER_BYTES + sz - 1) / sz;
  endfunction

  function automatic grant_t serve(logic [1:0] f, logic [15:0] req, logic [17:0] a);
    grant_t r;
    int cls, sz, p, slot;
    r = '0;
    cls = 0;
    if (f == scpa_pkg::FUNC_ALLOC) begin
      if (req > scpa_pkg::MAX_CLASS_BYTES) begin
        r.status = scpa_pkg::ST_TOO_LARGE;
        return r;
      end
      while ((16 << cls) < req) cls++;
      sz = 16 << cls;
      p = -1;
      for (int k = 0; k < claimed; k++)
        if (p < 0 && pg_class[k] == cls + 1 &&
            (pg_head[k] != 0 || pg_top[k] > hdr_slots(sz))) p = k;
      if (p < 0) begin
        if (claimed >= POOL_PAGES) begin
          r.status = scpa_pkg::ST_NO_PAGES;
          return r;
        end
        p = claimed;
        claimed++;
        pg_class[p] = 4'(cls + 1);
        pg_head[p] = '0;
        pg_top[p] = 9'(4096 / sz);
      end
      if (pg_head[p] != 0) begin
        slot = pg_head[p];
        pg_head[p] = link_mem[p*256 + slot % 256];
      end else begin
        pg_top[p] = pg_top[p] - 9'd1;
        slot = pg_top[p];
      end
      r.addr = 18'(p * 4096 + slot * sz);
      r.bytes = 12'(sz);
      r.status = scpa_pkg::ST_OK;
    end else if (f == scpa_pkg::FUNC_FREE || f == scpa_pkg::FUNC_QUERY) begin
      p = a / 4096;
      if (p >= POOL_PAGES || p >= claimed || pg_class[p] == 0 || pg_class[p] > 8) begin
        r.status = scpa_pkg::ST_UNASSIGN;
        return r;
      end
      sz = 16 << (pg_class[p] - 1);
      if (f == scpa_pkg::FUNC_FREE) begin
        slot = (a % 4096) / sz;
        // slots inside the header are dropped silently
        if (slot >= hdr_slots(sz) && slot < 256) begin
          link_mem[p*256 + slot] = pg_head[p];
          pg_head[p] = 9'(slot);
        end
      end
      r.bytes = 12'(sz);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t g, exp_g;
    if (!rst_ni) begin
      for (int k = 0; k < POOL_PAGES; k++) pg_class[k] = '0;
      claimed = 0;
      grant_q.delete();
      fail_count = 0;
    end else begin
      if (done_o) begin
        g = '{granted_address_o, object_bytes_o, status_o};
        if (grant_q.size() == 0) begin
          $error("result with nothing expected: addr %0h bytes %0d status %0d",
                 g.addr, g.bytes, g.status);
          fail_count++;
        end else begin
          exp_g = grant_q.pop_front();
          if (g.addr !== exp_g.addr) begin
            $error("granted_address: expected %0h, got %0h", exp_g.addr, g.addr);
            fail_count++;
          end
          if (g.bytes !== exp_g.bytes) begin
            $error("object_bytes: expected %0d, got %0d", exp_g.bytes, g.bytes);
            fail_count++;
          end
          if (g.status !== exp_g.status) begin
            $error("status: expected %0d, got %0d", exp_g.status, g.status);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        grant_q.push_back(serve(func_i, request_size_i, object_address_i));
    end
    pending_count = grant_q.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Testbench top: drives allocate, free, query and reserved transactions and reports the verdict.
module testbench;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func_i = '0;
  logic [15:0] request_size_i = '0;
  logic [17:0] object_address_i = '0;
  logic        done_o;
  logic [17:0] granted_address_o;
  logic [11:0] object_bytes_o;
  logic [1:0]  status_o;
  int          fail_count, pending_count;
  int          idle_pct;
  int          stall_cycles = 0;
  logic [17:0] granted_log [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  size_class_page_allocator u_top (.*);
  scpa_checker u_chk (.*);

  // watchdog on cycles with no accepted transaction or result
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 5000) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (done_o && status_o == scpa_pkg::ST_OK && granted_address_o != 0)
      granted_log.push_back(granted_address_o);

  // start stays high after acceptance until the next transaction or an idle cycle
  task automatic issue(logic [1:0] f, logic [15:0] req, logic [17:0] a);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    func_i <= f;
    request_size_i <= req;
    object_address_i <= a;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [15:0] rand_size();
    case ($urandom_range(9))
      0: return 16'($urandom_range(15));
      1: return 16'($urandom);
      2: return 16'(16 << $urandom_range(7));
      default: return 16'($urandom_range(2048));
    endcase
  endfunction

  function automatic logic [17:0] rand_addr();
    int k;
    if (granted_log.size() != 0 && $urandom_range(9) < 7) begin
      k = $urandom_range(granted_log.size() - 1);
      return granted_log[k] + 18'($urandom_range(3) == 0 ? $urandom_range(15) : 0);
    end
    return 18'($urandom);
  endfunction

  task automatic random_phase(int n, int pct);
    int r;
    idle_pct = pct;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 50) issue(scpa_pkg::FUNC_ALLOC, rand_size(), 18'($urandom));
      else if (r < 80) issue(scpa_pkg::FUNC_FREE, 16'($urandom), rand_addr());
      else if (r < 95) issue(scpa_pkg::FUNC_QUERY, 16'($urandom), rand_addr());
      else issue(scpa_pkg::FUNC_RSVD, 16'($urandom), 18'($urandom));
    end
  endtask

  initial begin
    idle_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, every function, header free, double free, errors
    issue(scpa_pkg::FUNC_QUERY, 16'd0, 18'd0);
    issue(scpa_pkg::FUNC_FREE, 16'd0, 18'h3FFFF);
    issue(scpa_pkg::FUNC_ALLOC, 16'd0, 18'd0);
    issue(scpa_pkg::FUNC_ALLOC, 16'd15, 18'd0);
    issue(scpa_pkg::FUNC_ALLOC, 16'd17, 18'd0);
    issue(scpa_pkg::FUNC_ALLOC, 16'd2048, 18'd0);
    issue(scpa_pkg::FUNC_ALLOC, 16'd2049, 18'd0);
    issue(scpa_pkg::FUNC_ALLOC, 16'hFFFF, 18'h3FFFF);
    issue(scpa_pkg::FUNC_FREE, 16'd0, 18'd5);
    issue(scpa_pkg::FUNC_FREE, 16'd0, 18'd4080);
    issue(scpa_pkg::FUNC_FREE, 16'd0, 18'd4080);
    issue(scpa_pkg::FUNC_ALLOC, 16'd16, 18'd0);
    issue(scpa_pkg::FUNC_ALLOC, 16'd16, 18'd0);
    issue(scpa_pkg::FUNC_ALLOC, 16'd16, 18'd0);
    issue(scpa_pkg::FUNC_QUERY, 16'd0, 18'd4096 * 2 + 18'd100);
    issue(scpa_pkg::FUNC_QUERY, 16'd0, 18'd4096 * 63);
    issue(scpa_pkg::FUNC_RSVD, 16'hFFFF, 18'h3FFFF);
    issue(scpa_pkg::FUNC_ALLOC, 16'd1024, 18'd0);
    issue(scpa_pkg::FUNC_ALLOC, 16'd1000, 18'd0);
    issue(scpa_pkg::FUNC_ALLOC, 16'd513, 18'd0);
    random_phase(200, 0);
    random_phase(200, 78);
    random_phase(200, 14);
    // exhaust the pool with large objects, then keep freeing and reusing
    idle_pct = 0;
    repeat (70) issue(scpa_pkg::FUNC_ALLOC, 16'd2048, 18'd0);
    random_phase(200, 0);
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
